### rtl/hvt_pkg.sv
// Shared types, widths and constants of the homogeneous vertex transform.
package hvt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = $clog2(NUM_REGS);
  localparam int REG_W     = 64;
  localparam int PROD_W    = 2 * COORD_W;
  // Row sums: three full products plus translation, kept exact.
  localparam int ROW_W     = PROD_W + 3;
  localparam int MAG_W     = ROW_W - 1;
  localparam int REM_W     = MAG_W + 1;
  localparam int DIV_STEPS = COORD_W;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);

  localparam logic [REG_W-1:0] ONE_FX = REG_W'(1) << FRAC_BITS;

  typedef enum logic {
    OP_POINT     = 1'b0,
    OP_DIRECTION = 1'b1
  } op_t;

  typedef logic [NUM_REGS-1:0][REG_W-1:0] matrix_t;

  // Identity matrix, register 7 first.
  localparam matrix_t MATRIX_RESET = {
    ONE_FX,            REG_W'(0),
    ONE_FX << COORD_W, REG_W'(0),
    REG_W'(0),         ONE_FX,
    REG_W'(0),         ONE_FX << COORD_W
  };

  typedef struct packed {
    op_t                        operation;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  result_x;
    logic signed [COORD_W-1:0]  result_y;
    logic signed [COORD_W-1:0]  result_z;
    logic                       zero_divisor;
    logic                       saturated;
  } out_item_t;

  typedef struct packed {
    op_t                        operation;
    logic signed [ROW_W-1:0]    row_x;
    logic signed [ROW_W-1:0]    row_y;
    logic signed [ROW_W-1:0]    row_z;
    logic signed [ROW_W-1:0]    row_w;
  } row_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### rtl/homogeneous_vertex_transform.sv
// Top level of the homogeneous 4x4 vertex transform.
//
// Channels: in_* takes one vertex (operation, coord_x/y/z, Q16.16) per
// transaction; out_* returns one transformed vertex per transaction with the
// zero_divisor and saturated flags. cfg_* writes one 64-bit matrix register
// (index 0..7, two Q16.16 entries, lower column in bits 63:32); it is always
// ready and is meant to be written only while no vertex is in flight.
// Order: the accepting edge registers the products; the row sum, the queue
// write, the classify stage, 32 divide steps and the output register follow
// in that order, and out_valid rises with the last of them when nothing stalls.
// Throughput: one vertex per clock while out_ready stays high; the divider is
// a 32-stage pipeline, one quotient bit per stage, three lanes.
// Reset (synchronous, rst_n low) empties all pipelines and the queue and loads
// the identity matrix. When the receiver stalls the back end holds; the
// 4-entry queue absorbs the front end, which then holds and drops in_ready.
module homogeneous_vertex_transform (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  hvt_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output hvt_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hvt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hvt_pkg::REG_W-1:0]      cfg_wdata
);
  import hvt_pkg::*;

  matrix_t   matrix_r;
  row_item_t q_in;
  row_item_t q_head;
  q_status_t q_status;
  logic      q_push;
  logic      q_pop;

  assign cfg_ready = 1'b1;

  // Hold the matrix; reset to identity.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_r <= MATRIX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      matrix_r[cfg_index] <= cfg_wdata;
    end
  end

  hvt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .matrix   (matrix_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_status (q_status),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  hvt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  hvt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_status  (q_status),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/hvt_front.sv
// Front end: accept vertices, form the four row sums of the matrix product.
module hvt_front (
  input  logic               clk,
  input  logic               rst_n,
  input  hvt_pkg::matrix_t   matrix,
  input  logic               in_valid,
  output logic               in_ready,
  input  hvt_pkg::in_item_t  in_data,
  input  hvt_pkg::q_status_t q_status,
  output logic               q_push,
  output hvt_pkg::row_item_t q_data
);
  import hvt_pkg::*;

  logic signed [PROD_W-1:0] prod_r   [4][3];
  logic signed [PROD_W-1:0] prod_nxt [4][3];
  op_t                      op1_r;
  logic                     s1_valid_r;
  logic                     s2_valid_r;
  row_item_t                row_r;
  row_item_t                row_nxt;
  logic                     adv;
  logic signed [ROW_W-1:0]  rows [4];

  function automatic logic signed [COORD_W-1:0] entry(matrix_t m, int r, int c);
    logic [REG_W-1:0] w;
    w = m[r * 2 + c / 2];
    return (c % 2 == 1) ? w[COORD_W-1:0] : w[REG_W-1:COORD_W];
  endfunction

  assign adv      = !s2_valid_r || !q_status.full;
  assign in_ready = adv;
  assign q_push   = s2_valid_r && !q_status.full;
  assign q_data   = row_r;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      prod_nxt[r][0] = entry(matrix, r, 0) * in_data.coord_x;
      prod_nxt[r][1] = entry(matrix, r, 1) * in_data.coord_y;
      prod_nxt[r][2] = entry(matrix, r, 2) * in_data.coord_z;
    end
  end

  // Exact sum, floor shift, then the translation entry for points and for the w row.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      rows[r] = (ROW_W'(prod_r[r][0]) + ROW_W'(prod_r[r][1]) + ROW_W'(prod_r[r][2]))
                >>> FRAC_BITS;
      if (op1_r == OP_POINT || r == 3) begin
        rows[r] = rows[r] + ROW_W'(entry(matrix, r, 3));
      end
    end
    row_nxt.operation = op1_r;
    row_nxt.row_x     = rows[0];
    row_nxt.row_y     = rows[1];
    row_nxt.row_z     = rows[2];
    row_nxt.row_w     = rows[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
    end
    if (adv) begin
      prod_r <= prod_nxt;
      op1_r  <= in_data.operation;
      row_r  <= row_nxt;
    end
  end

endmodule

### rtl/hvt_queue.sv
// Short queue of row sums between front and back end.
module hvt_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hvt_pkg::row_item_t push_data,
  input  logic               pop,
  output hvt_pkg::row_item_t head,
  output hvt_pkg::q_status_t status
);
  import hvt_pkg::*;

  row_item_t            mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_PTR_W:0]     count_r;

  assign head         = mem_r[rd_ptr_r];
  assign status.full  = (count_r == (Q_PTR_W + 1)'(Q_DEPTH));
  assign status.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + (Q_PTR_W + 1)'(push) - (Q_PTR_W + 1)'(pop);
    end
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && status.empty)) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && status.full)) else $error("push into full queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (Q_PTR_W + 1)'(Q_DEPTH)) else $error("queue count out of range");

endmodule

### rtl/hvt_back.sv
// Back end: perspective divide pipeline, saturation and output register.
module hvt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  hvt_pkg::row_item_t head,
  input  hvt_pkg::q_status_t q_status,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output hvt_pkg::out_item_t out_data
);
  import hvt_pkg::*;

  typedef struct packed {
    logic                     dir;
    logic                     zero;
    logic [2:0]               neg;
    logic [2:0]               ovf;
    logic [2:0][REM_W-1:0]    rem;
    logic [2:0][COORD_W-1:0]  quo;
    logic [2:0][COORD_W-1:0]  nlo;
    logic [MAG_W-1:0]         dmag;
    logic [2:0][COORD_W-1:0]  dres;
    logic                     dsat;
  } div_t;

  div_t      stg_r   [DIV_STEPS+1];
  logic      vld_r   [DIV_STEPS+1];
  div_t      stg0_nxt;
  out_item_t out_r;
  out_item_t out_nxt;
  logic      out_valid_r;
  logic      adv;

  function automatic logic [COORD_W:0] clip32(logic signed [ROW_W-1:0] v);
    if (v > ROW_W'(signed'({1'b0, {(COORD_W-1){1'b1}}}))) begin
      return {1'b1, 1'b0, {(COORD_W-1){1'b1}}};
    end else if (v < -(ROW_W'(1) <<< (COORD_W-1))) begin
      return {1'b1, 1'b1, {(COORD_W-1){1'b0}}};
    end
    return {1'b0, v[COORD_W-1:0]};
  endfunction

  // One quotient bit per lane.
  function automatic div_t step(div_t s);
    div_t             o;
    logic [REM_W-1:0] t;
    o = s;
    for (int k = 0; k < 3; k++) begin
      t = {s.rem[k][REM_W-2:0], s.nlo[k][COORD_W-1]};
      if (t >= {1'b0, s.dmag}) begin
        o.rem[k] = t - {1'b0, s.dmag};
        o.quo[k] = {s.quo[k][COORD_W-2:0], 1'b1};
      end else begin
        o.rem[k] = t;
        o.quo[k] = {s.quo[k][COORD_W-2:0], 1'b0};
      end
      o.nlo[k] = {s.nlo[k][COORD_W-2:0], 1'b0};
    end
    return o;
  endfunction

  assign adv       = !out_valid_r || out_ready;
  assign q_pop     = adv && !q_status.empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Classify the item: magnitudes, signs, overflow check, direct clip.
  always_comb begin
    logic signed [ROW_W-1:0] rv [3];
    logic [MAG_W-1:0]        mag;
    logic [PROD_W-1:0]       n;
    logic [COORD_W:0]        c;
    rv[0] = head.row_x;
    rv[1] = head.row_y;
    rv[2] = head.row_z;
    stg0_nxt      = '0;
    stg0_nxt.dir  = (head.operation == OP_DIRECTION);
    stg0_nxt.zero = !stg0_nxt.dir && (head.row_w == '0);
    stg0_nxt.dmag = head.row_w[ROW_W-1] ? MAG_W'(-head.row_w) : MAG_W'(head.row_w);
    for (int k = 0; k < 3; k++) begin
      mag = rv[k][ROW_W-1] ? MAG_W'(-rv[k]) : MAG_W'(rv[k]);
      n   = PROD_W'({mag, {FRAC_BITS{1'b0}}});
      stg0_nxt.neg[k] = rv[k][ROW_W-1] ^ head.row_w[ROW_W-1];
      stg0_nxt.ovf[k] = MAG_W'(n[PROD_W-1:COORD_W]) >= stg0_nxt.dmag;
      stg0_nxt.rem[k] = REM_W'(n[PROD_W-1:COORD_W]);
      stg0_nxt.nlo[k] = n[COORD_W-1:0];
      c = clip32(rv[k]);
      stg0_nxt.dres[k] = c[COORD_W-1:0];
      stg0_nxt.dsat    = stg0_nxt.dsat | c[COORD_W];
    end
  end

  // Apply sign, clip the quotient and pick the result of the mode; a zero divisor gives zeros and the flag.
  always_comb begin
    div_t                    s;
    logic [2:0][COORD_W-1:0] res;
    logic                    sat;
    logic                    big;
    s   = stg_r[DIV_STEPS];
    sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      big = s.ovf[k] ||
            (s.neg[k] ? (s.quo[k] > {1'b1, {(COORD_W-1){1'b0}}})
                      : s.quo[k][COORD_W-1]);
      if (big) begin
        res[k] = s.neg[k] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
        res[k] = s.neg[k] ? -s.quo[k] : s.quo[k];
      end
      sat = sat | big;
    end
    if (s.zero) begin
      out_nxt = '0;
      out_nxt.zero_divisor = 1'b1;
    end else if (s.dir) begin
      out_nxt.result_x     = s.dres[0];
      out_nxt.result_y     = s.dres[1];
      out_nxt.result_z     = s.dres[2];
      out_nxt.zero_divisor = 1'b0;
      out_nxt.saturated    = s.dsat;
    end else begin
      out_nxt.result_x     = res[0];
      out_nxt.result_y     = res[1];
      out_nxt.result_z     = res[2];
      out_nxt.zero_divisor = 1'b0;
      out_nxt.saturated    = sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= DIV_STEPS; i++) vld_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= !q_status.empty;
      for (int i = 0; i < DIV_STEPS; i++) vld_r[i+1] <= vld_r[i];
      out_valid_r <= vld_r[DIV_STEPS];
    end
    if (adv) begin
      stg_r[0] <= stg0_nxt;
      for (int i = 0; i < DIV_STEPS; i++) stg_r[i+1] <= step(stg_r[i]);
      out_r <= out_nxt;
    end
  end

  a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.zero_divisor |->
      !out_r.saturated && out_r.result_x == '0 && out_r.result_y == '0 &&
      out_r.result_z == '0) else $error("zero divisor with nonzero result");
  a_dir_no_zero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] && stg_r[0].dir |-> !stg_r[0].zero) else $error("zero flag in direction mode");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[DIV_STEPS] && adv |=> out_valid_r) else $error("result lost at output");

endmodule

### dv/tb_homogeneous_vertex_transform.sv
// Testbench for the homogeneous 4x4 vertex transform: predicts and checks every vertex.
`timescale 1ns / 100ps

module tb_homogeneous_vertex_transform;
  import hvt_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 50;
  localparam int HOLD_CYCLES    = 300;

  // Expected-vertex store plus a private copy of the matrix registers.
  class vertex_scoreboard;
    logic [REG_W-1:0] mtx [NUM_REGS];
    out_item_t        expected_q [$];
    int               errors;

    function new();
      errors = 0;
      for (int i = 0; i < NUM_REGS; i++) mtx[i] = '0;
      mtx[0] = ONE_FX << 32;
      mtx[2] = ONE_FX;
      mtx[5] = ONE_FX << 32;
      mtx[7] = ONE_FX;
    endfunction

    function void set_reg(int idx, logic [REG_W-1:0] val);
      mtx[idx] = val;
    endfunction

    function logic signed [31:0] entry(int r, int c);
      logic [REG_W-1:0] w;
      w = mtx[r * 2 + c / 2];
      return (c % 2 == 1) ? w[31:0] : w[63:32];
    endfunction

    // Exact row sum, floored to the fraction, then translation added.
    function logic signed [127:0] row_sum(int r, logic signed [31:0] x,
                                          logic signed [31:0] y,
                                          logic signed [31:0] z, bit with_trans);
      logic signed [127:0] acc;
      logic signed [127:0] e;
      acc = '0;
      e = entry(r, 0); acc = acc + e * 128'(x);
      e = entry(r, 1); acc = acc + e * 128'(y);
      e = entry(r, 2); acc = acc + e * 128'(z);
      acc = acc >>> FRAC_BITS;
      if (with_trans) begin
        e = entry(r, 3);
        acc = acc + e;
      end
      return acc;
    endfunction

    function logic signed [127:0] quotient(logic signed [127:0] num,
                                           logic signed [127:0] den);
      logic [127:0] n;
      logic [127:0] d;
      logic [127:0] q;
      bit           neg;
      neg = num[127] != den[127];
      n = (num[127] ? -num : num) << FRAC_BITS;
      d = den[127] ? -den : den;
      q = n / d;
      return neg ? -$signed(q) : $signed(q);
    endfunction

    function logic signed [31:0] clip(logic signed [127:0] v, inout bit sat);
      logic signed [127:0] hi_lim;
      logic signed [127:0] lo_lim;
      hi_lim = 128'sd2147483647;
      lo_lim = -128'sd2147483648;
      if (v > hi_lim) begin
        sat = 1;
        return 32'h7FFF_FFFF;
      end
      if (v < lo_lim) begin
        sat = 1;
        return 32'h8000_0000;
      end
      return v[31:0];
    endfunction

    // Note an accepted vertex: compute and queue its transformed result.
    function void note_vertex(in_item_t it);
      logic signed [127:0] rv [3];
      logic signed [127:0] w;
      out_item_t           res;
      bit                  point;
      bit                  sat;
      point = (it.operation == OP_POINT);
      sat = 0;
      for (int r = 0; r < 3; r++)
        rv[r] = row_sum(r, it.coord_x, it.coord_y, it.coord_z, point);
      res = '0;
      if (point) begin
        w = row_sum(3, it.coord_x, it.coord_y, it.coord_z, 1);
        if (w == 0) begin
          res.zero_divisor = 1;
          expected_q.insert(expected_q.size(), res);
          return;
        end
        for (int r = 0; r < 3; r++) rv[r] = quotient(rv[r], w);
      end
      res.result_x = clip(rv[0], sat);
      res.result_y = clip(rv[1], sat);
      res.result_z = clip(rv[2], sat);
      res.saturated = sat;
      expected_q.insert(expected_q.size(), res);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    // Check a result transaction against the oldest expected vertex.
    function void check_vertex(out_item_t got);
      out_item_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual %h", $time, got);
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("result_x", exp_r.result_x, got.result_x);
      compare_field("result_y", exp_r.result_y, got.result_y);
      compare_field("result_z", exp_r.result_z, got.result_z);
      compare_field("zero_divisor", 32'(exp_r.zero_divisor), 32'(got.zero_divisor));
      compare_field("saturated", 32'(exp_r.saturated), 32'(got.saturated));
    endfunction
  endclass

  logic             clk = 0;
  logic             rst_n = 0;
  logic             in_valid = 0;
  logic             in_ready;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 0;
  out_item_t        out_data;
  logic             cfg_valid = 0;
  logic             cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_wdata = '0;

  vertex_scoreboard sb = new();

  int snd_idle = 0;     // percent of cycles the sender idles
  int rcv_idle = 0;     // percent of cycles the receiver stalls
  bit hold_start = 0;   // request one long receiver hold-off
  bit hold_done = 0;
  int hold_cnt = 0;
  int quiet_cycles = 0;

  homogeneous_vertex_transform i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Receiver: random stalls, plus a single long hold-off counted here so the
  // internal queue fills and in_ready drops while the sender keeps offering.
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_ready <= 0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_start && !hold_done) begin
      hold_done <= 1;
      hold_cnt <= HOLD_CYCLES;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // Monitor: sample both channels at the rising edge; watchdog on silence.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_vertex(in_data);
      if (out_valid && out_ready) sb.check_vertex(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at a falling edge with valid still high.
  task automatic send_vertex(in_item_t it);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_op_xyz(op_t op, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_item_t it;
    it.operation = op;
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    send_vertex(it);
  endtask

  // Wait until every expected vertex is back, then let the pipe settle.
  task automatic drain();
    in_valid <= 0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write all eight registers back to back; valid stays high between writes.
  task automatic write_matrix(logic [REG_W-1:0] m [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_valid <= 1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= m[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(i, m[i]);
      @(negedge clk);
    end
    cfg_valid <= 0;
  endtask

  function automatic logic [31:0] rand_entry(int kind);
    case (kind)
      0:       return 32'($signed($urandom_range(524288)) - 262144);
      1:       return $urandom();
      2:       return 32'h7FFF_FFFF;
      default: return 32'h8000_0000;
    endcase
  endfunction

  // Build a matrix. Style: 0 projective w = z, 1 random small, at times with one
  // full-range register, 2 affine, 3 all maximum entries, 4 all minimum entries.
  task automatic make_matrix(int style, output logic [REG_W-1:0] m [NUM_REGS]);
    int kind;
    kind = (style == 3) ? 2 : (style == 4) ? 3 : 0;
    for (int i = 0; i < NUM_REGS; i++)
      m[i] = {rand_entry(kind), rand_entry(kind)};
    if (style == 1 && $urandom_range(1)) m[$urandom_range(7)] = {$urandom(), $urandom()};
    if (style == 0) begin
      m[6] = '0;
      m[7] = {32'(ONE_FX), 32'h0};
    end else if (style == 2) begin
      m[6] = '0;
      m[7] = {32'h0, 32'(ONE_FX)};
    end
  endtask

  function automatic logic [31:0] rand_coord();
    int pick;
    pick = $urandom_range(19);
    if (pick < 2) return $urandom();
    if (pick == 2) begin
      case ($urandom_range(4))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'h0;
        3:       return 32'hFFFF_FFFF;
        default: return 32'(ONE_FX);
      endcase
    end
    return 32'($signed($urandom_range(2097152)) - 1048576);
  endfunction

  task automatic send_random(int count);
    for (int n = 0; n < count; n++)
      send_op_xyz($urandom_range(3) == 0 ? OP_DIRECTION : OP_POINT,
                  rand_coord(), rand_coord(), rand_coord());
  endtask

  initial begin
    logic [REG_W-1:0] m [NUM_REGS];
    logic [31:0]      edge_vals [5];
    int               style;

    edge_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1, 32'hFFFF_FFFF};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Reset matrix is the identity: extremes through both operations.
    for (int i = 0; i < 5; i++) begin
      send_op_xyz(OP_POINT, edge_vals[i], edge_vals[(i + 1) % 5], edge_vals[(i + 2) % 5]);
      send_op_xyz(OP_DIRECTION, edge_vals[i], edge_vals[(i + 3) % 5], edge_vals[i]);
    end
    drain();

    // Zero projective row: every point hits a zero w; directions unaffected.
    for (int i = 0; i < NUM_REGS; i++) m[i] = {rand_entry(0), rand_entry(0)};
    m[6] = '0;
    m[7] = '0;
    write_matrix(m);
    send_op_xyz(OP_POINT, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_op_xyz(OP_POINT, 32'h0, 32'h0, 32'h0);
    send_op_xyz(OP_DIRECTION, 32'h0001_0000, 32'hFFFF_0000, 32'h0);
    drain();

    // Maximum entries saturate; register 7 gives the w row a unit z entry and no translation.
    make_matrix(3, m);
    m[7] = {32'(ONE_FX), 32'h0};
    write_matrix(m);
    send_op_xyz(OP_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1);
    send_op_xyz(OP_POINT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_op_xyz(OP_POINT, 32'h1, 32'h1, 32'h0);
    send_op_xyz(OP_DIRECTION, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_op_xyz(OP_POINT, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    drain();

    // Random part: three idling modes, four matrices each.
    for (int mode = 0; mode < 3; mode++) begin
      snd_idle = (mode == 0) ? 10 : (mode == 1) ? 82 : 0;
      rcv_idle = (mode == 0) ? 82 : (mode == 1) ? 10 : 0;
      for (int k = 0; k < 4; k++) begin
        style = (k == 3) ? 3 + (mode % 2) : k;
        make_matrix(style, m);
        write_matrix(m);
        if (mode == 2 && k == 1) hold_start = 1;
        send_random((k == 3) ? 20 : 105);
        drain();
      end
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
